### hdl/idq_pkg.sv
// Shared types, constants and ring arithmetic for the indexed double-ended queue.
package idq_pkg;

   localparam int DEPTH      = 1024;
   localparam int DATA_WIDTH = 32;
   localparam int SLOT_W     = $clog2(DEPTH);
   localparam int COUNT_W    = $clog2(DEPTH + 1);
   localparam int WORD_W     = 32;

   typedef enum logic [2:0] {
      FUNC_APPEND     = 3'd0,
      FUNC_DROP_FRONT = 3'd1,
      FUNC_DROP_BACK  = 3'd2,
      FUNC_READ       = 3'd3,
      FUNC_QUERY      = 3'd4
   } func_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   typedef struct packed {
      logic [2:0]        func;
      logic [WORD_W-1:0] value;
      logic [WORD_W-1:0] logical_index;
   } req_type;

   typedef struct packed {
      logic [WORD_W-1:0]  element;
      logic [1:0]         status;
      logic [COUNT_W-1:0] count;
      logic [WORD_W-1:0]  first_index;
      logic [WORD_W-1:0]  last_index;
   } rsp_type;

   typedef struct packed {
      logic                  wr_en;
      logic                  rd_en;
      logic [SLOT_W-1:0]     addr;
      logic [DATA_WIDTH-1:0] wr_data;
   } mem_req_type;

   // Ring slot at a given offset from the head; the offset is always below DEPTH.
   function automatic logic [SLOT_W-1:0] slot_of(input logic [SLOT_W-1:0] head,
                                                 input logic [SLOT_W-1:0] offset);
      logic [SLOT_W:0] sum;
      sum = {1'b0, head} + {1'b0, offset};
      if (sum >= (SLOT_W + 1)'(DEPTH)) begin
         sum = sum - (SLOT_W + 1)'(DEPTH);
      end
      return sum[SLOT_W-1:0];
   endfunction

endpackage

### hdl/idq_ram.sv
// Generic single-port synchronous RAM with a registered read.
module idq_ram #(
   parameter int WORDS = 1024,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic                     rd_en,
   input  logic [$clog2(WORDS)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [WORDS];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/idq_ctrl.sv
// Pointer state, command decode and result register of the queue.
module idq_ctrl
   import idq_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  req_type               req,
   input  logic [DATA_WIDTH-1:0] rd_data,
   output mem_req_type           mem_req,
   output logic                  rsp_strobe,
   output rsp_type               rsp
);

   logic [SLOT_W-1:0]  head_ff,  head_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [WORD_W-1:0]  front_ff, front_in;
   logic               strobe_ff;
   logic               elem_ff,  elem_in;
   status_type         status_ff, status_in;
   logic [COUNT_W-1:0] rsp_count_ff;
   logic [WORD_W-1:0]  rsp_first_ff, rsp_last_ff;
   logic [WORD_W-1:0]  offset;
   logic [COUNT_W-1:0] count_less;

   always_comb begin
      head_in    = head_ff;
      count_in   = count_ff;
      front_in   = front_ff;
      status_in  = ST_OK;
      elem_in    = 1'b0;
      mem_req    = '0;
      offset     = req.logical_index - front_ff;
      count_less = count_ff - COUNT_W'(1);
      mem_req.wr_data = req.value[DATA_WIDTH-1:0];
      if (accept) begin
         unique case (req.func)
            FUNC_APPEND: begin
               if (count_ff == COUNT_W'(DEPTH)) begin
                  status_in = ST_FULL;
               end else begin
                  mem_req.wr_en = 1'b1;
                  mem_req.addr  = slot_of(head_ff, count_ff[SLOT_W-1:0]);
                  count_in      = count_ff + COUNT_W'(1);
               end
            end
            FUNC_DROP_FRONT: begin
               if (count_ff == '0) begin
                  status_in = ST_EMPTY;
               end else begin
                  mem_req.rd_en = 1'b1;
                  mem_req.addr  = head_ff;
                  elem_in       = 1'b1;
                  head_in       = slot_of(head_ff, SLOT_W'(1));
                  front_in      = front_ff + WORD_W'(1);
                  count_in      = count_less;
               end
            end
            FUNC_DROP_BACK: begin
               if (count_ff == '0) begin
                  status_in = ST_EMPTY;
               end else begin
                  mem_req.rd_en = 1'b1;
                  mem_req.addr  = slot_of(head_ff, count_less[SLOT_W-1:0]);
                  elem_in       = 1'b1;
                  count_in      = count_less;
               end
            end
            FUNC_READ: begin
               // The unsigned distance from the front also rejects indices behind it.
               if (offset >= WORD_W'(count_ff)) begin
                  status_in = ST_RANGE;
               end else begin
                  mem_req.rd_en = 1'b1;
                  mem_req.addr  = slot_of(head_ff, offset[SLOT_W-1:0]);
                  elem_in       = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff   <= '0;
         count_ff  <= '0;
         front_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         head_ff   <= head_in;
         count_ff  <= count_in;
         front_ff  <= front_in;
         strobe_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         elem_ff      <= elem_in;
         status_ff    <= status_in;
         rsp_count_ff <= count_in;
         rsp_first_ff <= front_in;
         rsp_last_ff  <= front_in + WORD_W'(count_in) - WORD_W'(1);
      end
   end

   // The element arrives from the RAM in the same cycle as the strobe.
   assign rsp_strobe      = strobe_ff;
   assign rsp.element     = elem_ff ? WORD_W'(rd_data) : '0;
   assign rsp.status      = status_ff;
   assign rsp.count       = rsp_count_ff;
   assign rsp.first_index = rsp_first_ff;
   assign rsp.last_index  = rsp_last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(DEPTH))
      else $error("held count exceeds the ring depth");

   a_strobe_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_strobe)
      else $error("accepted transfer produced no result");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !accept |=> !rsp_strobe)
      else $error("result strobe without an accepted transfer");

   a_append_grows: assert property (@(posedge clock) disable iff (reset)
      (accept && req.func == FUNC_APPEND && count_ff != COUNT_W'(DEPTH))
      |=> count_ff == $past(count_ff) + COUNT_W'(1))
      else $error("append did not grow the queue by one");

   a_mem_idle: assert property (@(posedge clock) disable iff (reset)
      (mem_req.wr_en || mem_req.rd_en) |-> accept && !(mem_req.wr_en && mem_req.rd_en))
      else $error("memory access outside an accepted transfer");

endmodule

### hdl/indexed_double_ended_queue_top.sv
// Latency: the result of a transfer is strobed in the cycle after start is taken.
// Throughput: one transfer per cycle; busy is tied low, so no command is ever held off.
// The latency is set by the single RAM port with its registered read.
// Reset clears the head slot, the count and the front index; the ring contents stay undefined.
// Results cannot be stalled by the receiver and are shown for exactly one cycle.
module indexed_double_ended_queue_top
   import idq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   mem_req_type           mem_req;
   logic [DATA_WIDTH-1:0] rd_data;
   logic                  accept;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   idq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req        (req_data),
      .rd_data    (rd_data),
      .mem_req    (mem_req),
      .rsp_strobe (rsp_strobe),
      .rsp        (rsp_data)
   );

   idq_ram #(
      .WORDS (DEPTH),
      .WIDTH (DATA_WIDTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_req.wr_en),
      .rd_en   (mem_req.rd_en),
      .addr    (mem_req.addr),
      .wr_data (mem_req.wr_data),
      .rd_data (rd_data)
   );

endmodule

### dv/testbench.sv
// Self-checking testbench for the indexed double-ended queue: directed corners, then paced random traffic.
module testbench;
   import idq_pkg::*;

   localparam int IDLE_LIMIT = 1000;
   localparam int TAIL_CYCLES = 4;
   localparam logic [2:0] FUNC_UNUSED_FIRST = 3'd5;
   localparam logic [2:0] FUNC_UNUSED_MID   = 3'd6;
   localparam logic [2:0] FUNC_UNUSED_LAST  = 3'd7;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_strobe;
   rsp_type rsp_data;

   // Shadow copy of the queue, advanced at every accepted command transfer.
   logic [DATA_WIDTH-1:0] ring_mem [DEPTH];
   int                    head_slot = 0;
   int                    held = 0;
   logic [WORD_W-1:0]     front_idx = '0;

   rsp_type pending_rsp_q[$];
   int      fail_count = 0;
   int      idle_cycles = 0;
   int      burst_left = 20;

   indexed_double_ended_queue_top uut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always #5 clock = ~clock;

   function automatic int ring_slot(input int offset);
      return (head_slot + offset) % DEPTH;
   endfunction

   function automatic rsp_type apply_command(input req_type item);
      rsp_type           r;
      logic [WORD_W-1:0] offset;
      r = '0;
      r.status = ST_OK;
      case (item.func)
         FUNC_APPEND: begin
            if (held >= DEPTH) begin
               r.status = ST_FULL;
            end else begin
               ring_mem[ring_slot(held)] = item.value[DATA_WIDTH-1:0];
               held++;
            end
         end
         FUNC_DROP_FRONT: begin
            if (held == 0) begin
               r.status = ST_EMPTY;
            end else begin
               r.element = WORD_W'(ring_mem[head_slot]);
               head_slot = ring_slot(1);
               front_idx = front_idx + 1'b1;
               held--;
            end
         end
         FUNC_DROP_BACK: begin
            if (held == 0) begin
               r.status = ST_EMPTY;
            end else begin
               r.element = WORD_W'(ring_mem[ring_slot(held - 1)]);
               held--;
            end
         end
         FUNC_READ: begin
            // The offset is taken modulo 2^32, so indices below the front land far out of range.
            offset = item.logical_index - front_idx;
            if (offset >= WORD_W'(held)) begin
               r.status = ST_RANGE;
            end else begin
               r.element = WORD_W'(ring_mem[ring_slot(int'(offset))]);
            end
         end
         default: begin
         end
      endcase
      r.count = COUNT_W'(held);
      r.first_index = front_idx;
      r.last_index = front_idx + WORD_W'(held) - 1'b1;
      return r;
   endfunction

   function automatic req_type cmd(input logic [2:0] code, input logic [WORD_W-1:0] value,
                                   input logic [WORD_W-1:0] index);
      req_type it;
      it.func = code;
      it.value = value;
      it.logical_index = index;
      return it;
   endfunction

   // Weights are percentages; what is left over goes to queries and the spare codes.
   function automatic req_type random_command(input int w_app, input int w_front,
                                              input int w_back, input int w_read);
      req_type it;
      int      pick;
      int      aim;
      it.value = $urandom;
      it.logical_index = $urandom;
      pick = $urandom_range(99);
      if (pick < w_app) begin
         it.func = FUNC_APPEND;
      end else if (pick < w_app + w_front) begin
         it.func = FUNC_DROP_FRONT;
      end else if (pick < w_app + w_front + w_back) begin
         it.func = FUNC_DROP_BACK;
      end else if (pick < w_app + w_front + w_back + w_read) begin
         it.func = FUNC_READ;
      end else if (pick < 98) begin
         it.func = FUNC_QUERY;
      end else begin
         it.func = 3'($urandom_range(FUNC_UNUSED_LAST, FUNC_UNUSED_FIRST));
      end
      if (it.func == FUNC_READ) begin
         aim = $urandom_range(99);
         if (aim < 55 && held > 0) begin
            it.logical_index = front_idx + WORD_W'($urandom_range(held - 1));
         end else if (aim < 75) begin
            case ($urandom_range(3))
               0: it.logical_index = front_idx;
               1: it.logical_index = front_idx + WORD_W'(held) - 1'b1;
               2: it.logical_index = front_idx + WORD_W'(held);
               default: it.logical_index = front_idx - 1'b1;
            endcase
         end
      end
      return it;
   endfunction

   // Called just after a rising edge; returns after the edge that takes the transfer and any random pause after it.
   task automatic send_item(input req_type item);
      bit taken;
      int gap;
      start <= 1'b1;
      req_data <= item;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = (busy === 1'b0);
         @(posedge clock);
      end
      pending_rsp_q.push_back(apply_command(item));
      burst_left--;
      if (burst_left <= 0) begin
         gap = $urandom_range(6);
         if ($urandom_range(99) < 3) begin
            wait_drained();
         end else if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(9) == 0) ? 150 : $urandom_range(1, 30);
      end
   endtask

   // Stops sending and holds off until every outstanding result has been seen.
   task automatic wait_drained();
      start <= 1'b0;
      do @(posedge clock); while (pending_rsp_q.size() != 0);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   task automatic test_reset_state();
      send_item(cmd(FUNC_QUERY, '0, '0));
   endtask

   task automatic test_empty_queue();
      send_item(cmd(FUNC_DROP_FRONT, '1, '1));
      send_item(cmd(FUNC_DROP_BACK, '1, '1));
      send_item(cmd(FUNC_READ, '1, '0));
      send_item(cmd(FUNC_READ, '0, '1));
      send_item(cmd(FUNC_UNUSED_FIRST, '1, '1));
      send_item(cmd(FUNC_UNUSED_MID, 32'h5A5A_5A5A, 32'hA5A5_A5A5));
      send_item(cmd(FUNC_UNUSED_LAST, '0, '0));
      wait_drained();
   endtask

   task automatic test_field_extremes();
      send_item(cmd(FUNC_APPEND, '0, '1));
      send_item(cmd(FUNC_APPEND, '1, '0));
      send_item(cmd(FUNC_APPEND, 32'hA5A5_A5A5, '1));
      send_item(cmd(FUNC_READ, '1, 32'd0));
      send_item(cmd(FUNC_READ, '0, 32'd2));
      send_item(cmd(FUNC_READ, '0, 32'd3));
      send_item(cmd(FUNC_READ, '0, '1));
      send_item(cmd(FUNC_READ, '0, 32'd1));
      send_item(cmd(FUNC_DROP_FRONT, '0, '0));
      send_item(cmd(FUNC_READ, '0, 32'd0));
      send_item(cmd(FUNC_READ, '0, 32'd1));
      send_item(cmd(FUNC_DROP_BACK, '0, '0));
      send_item(cmd(FUNC_DROP_FRONT, '0, '0));
      send_item(cmd(FUNC_DROP_BACK, '0, '0));
      send_item(cmd(FUNC_DROP_FRONT, '0, '0));
      send_item(cmd(FUNC_READ, '0, 32'd2));
      send_item(cmd(FUNC_QUERY, '1, '1));
      wait_drained();
   endtask

   task automatic test_fill_to_full();
      while (held < DEPTH) begin
         send_item(random_command(92, 2, 2, 3));
      end
      // Appends against a full store must be refused without side effects.
      repeat (30) send_item(random_command(70, 10, 5, 13));
      wait_drained();
   endtask

   task automatic test_partial_drain();
      while (held > 600) begin
         send_item(random_command(4, 40, 40, 14));
      end
   endtask

   task automatic test_wrapped_traffic();
      // The head has moved on from slot zero, and the ring wrapped while it was being filled.
      repeat (250) send_item(random_command(40, 20, 15, 20));
   endtask

   task automatic check_field(input string name, input logic [WORD_W-1:0] want,
                              input logic [WORD_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %h, actual %h", name, want, got);
         fail_count++;
      end
   endtask

   always @(negedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (pending_rsp_q.size() == 0) begin
            $error("result strobed with no expectation waiting");
            fail_count++;
         end else begin
            want = pending_rsp_q.pop_front();
            check_field("element", want.element, rsp_data.element);
            check_field("status", WORD_W'(want.status), WORD_W'(rsp_data.status));
            check_field("count", WORD_W'(want.count), WORD_W'(rsp_data.count));
            check_field("first_index", want.first_index, rsp_data.first_index);
            check_field("last_index", want.last_index, rsp_data.last_index);
         end
      end
   end

   always @(negedge clock) begin
      if ((start === 1'b1 && busy === 1'b0) || rsp_strobe === 1'b1) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_state();
      test_empty_queue();
      test_field_extremes();
      test_fill_to_full();
      test_partial_drain();
      test_wrapped_traffic();
      wait_drained();
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

### sim.f
hdl/idq_pkg.sv
hdl/idq_ram.sv
hdl/idq_ctrl.sv
hdl/indexed_double_ended_queue_top.sv
dv/testbench.sv
